### rtl/lbde_pkg.sv
// ----------------------------------------------------------------------------
// lbde_pkg
// Shared types and constants for the life board draw-and-evolve block.
// ----------------------------------------------------------------------------
package lbde_pkg;

	// field and register widths
	localparam int DIM_W      = 7;   // board width / height registers
	localparam int GEN_W      = 16;  // generation count register
	localparam int CUR_W      = 6;   // cursor coordinates
	localparam int KEY_W      = 8;
	localparam int CFG_AW     = 2;
	localparam int CFG_DW     = 16;
	localparam int ROWIDX_W   = 6;
	localparam int CELLS_W    = 64;
	localparam int S_TDATA_W  = 8;   // key_code
	localparam int M_TDATA_W  = 72;  // row_index, row_cells, zero fill

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_GENS   = 2'd2;

	// request kinds
	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

	// key bytes
	localparam logic [KEY_W-1:0] KEY_UP    = 8'h77;  // w
	localparam logic [KEY_W-1:0] KEY_DOWN  = 8'h73;  // s
	localparam logic [KEY_W-1:0] KEY_LEFT  = 8'h61;  // a
	localparam logic [KEY_W-1:0] KEY_RIGHT = 8'h64;  // d
	localparam logic [KEY_W-1:0] KEY_PEN   = 8'h78;  // x

	// board read address select
	typedef enum logic [1:0] {
		RD_ROW,        // row counter
		RD_ROW_P1,     // row counter + 1
		RD_ROW_P2,     // row counter + 2
		RD_CURSOR      // cursor row
	} rd_sel_t;

	// controller -> datapath commands
	typedef struct packed {
		logic    key_apply;  // move cursor / toggle pen from the accepted key
		logic    run_start;  // drop rows outside board, load generation count
		rd_sel_t rd_sel;
		logic    win_load;   // prime the row window with row 0
		logic    gen_row;    // compute and write one evolved row, slide window
		logic    gen_dec;    // one generation done
		logic    row_clr;    // row counter back to 0
		logic    emit_load;  // load output register, write masked row back
		logic    paint_wr;   // set the cell under the cursor
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic pen_next;  // pen state after the key on the input
		logic gen_zero;
		logic gen_last;
		logic row_last;  // row counter on the bottom row in use
		logic out_free;  // output register empty or emptying this cycle
	} sts_t;

endpackage

### rtl/lbde_ram.sv
// ----------------------------------------------------------------------------
// lbde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbde_ram #(
	parameter  int WIDTH = 64,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/lbde_dpath.sv
// ----------------------------------------------------------------------------
// lbde_dpath
// Board datapath: config registers, cursor and pen, board RAM with row valid
// bits, three-row window with the life rule, counters and output register.
// ----------------------------------------------------------------------------
module lbde_dpath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [lbde_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [lbde_pkg::CFG_DW-1:0]       cfg_wdata,
	// input item payload
	input  logic [lbde_pkg::S_TDATA_W-1:0]    s_tdata,
	// output item
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lbde_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	// control
	input  lbde_pkg::cmd_t                    cmd,
	output lbde_pkg::sts_t                    sts
);
	import lbde_pkg::*;

	localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// configuration registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [GEN_W-1:0] gens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
			gens_q   <= GEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_WIDTH:  width_q  <= cfg_wdata[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
				CFG_GENS:   gens_q   <= cfg_wdata[GEN_W-1:0];
				default: ;
			endcase
		end
	end

	// board size in use, clamped into 1..max
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0)
			w_eff = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// column mask
	logic [MAX_WIDTH-1:0] col_mask;

	always_comb begin
		for (int c = 0; c < MAX_WIDTH; c++) begin
			col_mask[c] = (DIM_W'(c) < w_eff);
		end
	end

	// cursor and pen
	logic [CUR_W-1:0] cur_row_q;
	logic [CUR_W-1:0] cur_col_q;
	logic             pen_q;
	logic [CUR_W-1:0] row_max;
	logic [CUR_W-1:0] col_max;
	logic [CUR_W-1:0] row_sat;
	logic [CUR_W-1:0] col_sat;
	logic [CUR_W-1:0] row_nxt;
	logic [CUR_W-1:0] col_nxt;
	logic [KEY_W-1:0] key;

	assign key     = s_tdata[KEY_W-1:0];
	assign row_max = CUR_W'(h_eff - DIM_W'(1));
	assign col_max = CUR_W'(w_eff - DIM_W'(1));

	always_comb begin
		row_sat = (cur_row_q > row_max) ? row_max : cur_row_q;
		col_sat = (cur_col_q > col_max) ? col_max : cur_col_q;
		row_nxt = row_sat;
		col_nxt = col_sat;
		case (key)
			KEY_UP:    if (row_sat != '0)     row_nxt = row_sat - CUR_W'(1);
			KEY_DOWN:  if (row_sat < row_max) row_nxt = row_sat + CUR_W'(1);
			KEY_LEFT:  if (col_sat != '0)     col_nxt = col_sat - CUR_W'(1);
			KEY_RIGHT: if (col_sat < col_max) col_nxt = col_sat + CUR_W'(1);
			default: ;
		endcase
	end

	assign sts.pen_next = pen_q ^ (key == KEY_PEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			pen_q     <= 1'b0;
		end else if (cmd.key_apply) begin
			cur_row_q <= row_nxt;
			cur_col_q <= col_nxt;
			pen_q     <= sts.pen_next;
		end
	end

	// row and generation counters
	logic [DIM_W-1:0] row_q;
	logic [GEN_W-1:0] gen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			gen_q <= '0;
		end else begin
			if (cmd.row_clr)
				row_q <= '0;
			else if (cmd.gen_row || cmd.emit_load)
				row_q <= row_q + DIM_W'(1);
			if (cmd.run_start)
				gen_q <= gens_q;
			else if (cmd.gen_dec)
				gen_q <= gen_q - GEN_W'(1);
		end
	end

	assign sts.gen_zero = (gen_q == '0);
	assign sts.gen_last = (gen_q == GEN_W'(1));
	assign sts.row_last = (row_q == h_eff - DIM_W'(1));

	// board read address and row value
	logic [DIM_W-1:0]     rd_row;
	logic [DIM_W-1:0]     rd_row_s1;
	logic [MAX_WIDTH-1:0] rdata_s1;
	logic [MAX_WIDTH-1:0] row_raw;
	logic [MAX_WIDTH-1:0] row_val;
	logic [MAX_HEIGHT-1:0] vld_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_ROW:    rd_row = row_q;
			RD_ROW_P1: rd_row = row_q + DIM_W'(1);
			RD_ROW_P2: rd_row = row_q + DIM_W'(2);
			RD_CURSOR: rd_row = DIM_W'(cur_row_q);
			default:   rd_row = row_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_row_s1 <= rd_row;
	end

	// stored row as written; rows never written read as dead
	assign row_raw = vld_q[rd_row_s1[ROW_AW-1:0]] ? rdata_s1 : '0;

	// rows beyond the board read as dead, columns beyond it masked
	assign row_val = (rd_row_s1 < h_eff) ? (row_raw & col_mask) : '0;

	// three-row window and life rule
	logic [MAX_WIDTH-1:0] up_q;
	logic [MAX_WIDTH-1:0] mid_q;
	logic [MAX_WIDTH-1:0] next_row;

	always_comb begin
		logic [MAX_WIDTH-1:0] ul, ur, ml, mr, dl, dr;
		logic [3:0]           cnt;
		ul = up_q << 1;
		ur = up_q >> 1;
		ml = mid_q << 1;
		mr = mid_q >> 1;
		dl = row_val << 1;
		dr = row_val >> 1;
		for (int c = 0; c < MAX_WIDTH; c++) begin
			cnt = 4'(ul[c]) + 4'(up_q[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c]) +
				4'(dl[c]) + 4'(row_val[c]) + 4'(dr[c]);
			next_row[c] = (cnt == 4'd3) || (mid_q[c] && (cnt == 4'd2));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			up_q  <= '0;
			mid_q <= row_val;
		end else if (cmd.gen_row) begin
			up_q  <= mid_q;
			mid_q <= row_val;
		end
	end

	// board write port
	logic                 ram_we;
	logic [ROW_AW-1:0]    ram_waddr;
	logic [MAX_WIDTH-1:0] ram_wdata;
	logic [MAX_WIDTH-1:0] col_bit;

	assign col_bit   = MAX_WIDTH'(1) << cur_col_q;
	assign ram_we    = cmd.gen_row || cmd.emit_load || cmd.paint_wr;
	assign ram_waddr = cmd.paint_wr ? cur_row_q[ROW_AW-1:0] : row_q[ROW_AW-1:0];

	// painting keeps cells outside the current width until the next run
	always_comb begin
		if (cmd.paint_wr)
			ram_wdata = row_raw | col_bit;
		else if (cmd.gen_row)
			ram_wdata = next_row & col_mask;
		else
			ram_wdata = row_val;
	end

	// row valid bits: set on write, rows outside the board dropped on a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int r = 0; r < MAX_HEIGHT; r++) begin
				if (cmd.run_start && (DIM_W'(r) >= h_eff))
					vld_q[r] <= 1'b0;
				else if (ram_we && (ram_waddr == ROW_AW'(r)))
					vld_q[r] <= 1'b1;
			end
		end
	end

	lbde_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_board (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_row[ROW_AW-1:0]),
		.rdata (rdata_s1)
	);

	// output register
	logic                 out_vld_q;
	logic [ROWIDX_W-1:0]  out_idx_q;
	logic [MAX_WIDTH-1:0] out_cells_q;
	logic                 out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.emit_load)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_idx_q   <= row_q[ROWIDX_W-1:0];
			out_cells_q <= row_val;
			out_last_q  <= sts.row_last;
		end
	end

	assign sts.out_free = !out_vld_q || m_tready;
	assign m_tvalid     = out_vld_q;
	assign m_tlast      = out_last_q;
	assign m_tdata      = {2'b00, CELLS_W'(out_cells_q), out_idx_q};

endmodule

### rtl/lbde_ctrl.sv
// ----------------------------------------------------------------------------
// lbde_ctrl
// Sequencer: key handling and painting, generation sweeps over the board
// rows, and row emission.
// ----------------------------------------------------------------------------
module lbde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           s_tuser,
	output lbde_pkg::cmd_t cmd,
	input  lbde_pkg::sts_t sts
);
	import lbde_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAINT_RD,
		ST_PAINT_WR,
		ST_RUN_CHK,
		ST_GEN_START,
		ST_GEN_LOAD,
		ST_GEN_ROW,
		ST_EMIT_RD,
		ST_EMIT_LOAD
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = RD_ROW;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == REQ_RUN) begin
						cmd.run_start = 1'b1;
						state_d = ST_RUN_CHK;
					end else begin
						cmd.key_apply = 1'b1;
						if (sts.pen_next)
							state_d = ST_PAINT_RD;
					end
				end
			end
			ST_PAINT_RD: begin
				cmd.rd_sel = RD_CURSOR;
				state_d = ST_PAINT_WR;
			end
			ST_PAINT_WR: begin
				cmd.paint_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RUN_CHK: begin
				cmd.row_clr = 1'b1;
				state_d = sts.gen_zero ? ST_EMIT_RD : ST_GEN_START;
			end
			ST_GEN_START: begin
				// read row 0
				state_d = ST_GEN_LOAD;
			end
			ST_GEN_LOAD: begin
				cmd.win_load = 1'b1;
				cmd.rd_sel = RD_ROW_P1;
				state_d = ST_GEN_ROW;
			end
			ST_GEN_ROW: begin
				cmd.gen_row = 1'b1;
				cmd.rd_sel = RD_ROW_P2;
				if (sts.row_last) begin
					cmd.row_clr = 1'b1;
					cmd.gen_dec = 1'b1;
					state_d = sts.gen_last ? ST_EMIT_RD : ST_GEN_START;
				end
			end
			ST_EMIT_RD: begin
				if (sts.out_free)
					state_d = ST_EMIT_LOAD;
			end
			ST_EMIT_LOAD: begin
				cmd.emit_load = 1'b1;
				state_d = sts.row_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/life_board_draw_and_evolve.sv
// ----------------------------------------------------------------------------
// life_board_draw_and_evolve
// Game of Life board with a drawing cursor; run items evolve the board and
// stream it out one row per item.
//
//   channel  dir  payload                                   accept
//   s_*      in   tdata[7:0] key_code, tuser req_type       s_tvalid & s_tready
//   m_*      out  tdata[5:0] row_index, [69:6] row_cells,   m_tvalid & m_tready
//                 tlast last_row
//   cfg_*    in   addr 0 width, 1 height, 2 generations     cfg_we
//
// A draw item with the pen up is taken in the idle state alone; with the pen
// down it adds a board row read-modify-write. A run item sweeps the board
// RAM once per generation, one row a cycle through a three-row window, and
// then emits each row with a read state and a load state. Output stalls hold
// the emission sweep. Input is not taken during a run. Reset clears the
// board through per-row valid bits, no sweep.
// ----------------------------------------------------------------------------
module life_board_draw_and_evolve #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [lbde_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [lbde_pkg::CFG_DW-1:0]    cfg_wdata,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lbde_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] key_code
	input  logic                           s_tuser,   // [0] req_type
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lbde_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] row_index, [69:6] row_cells
	output logic                           m_tlast
);
	import lbde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lbde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	lbde_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
